>>> sv/cfr_pkg.sv
// Shared types, codes and reset values for the command frame receiver.
`default_nettype none

package cfr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_MARK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CSUM_EN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd7;

    // reset values
    localparam logic [BYTE_W-1:0] RST_START_MARK  = 8'd67;
    localparam logic [BYTE_W-1:0] RST_OPEN_MARK   = 8'd58;
    localparam logic [BYTE_W-1:0] RST_END_MARK    = 8'h3B;
    localparam logic              RST_CSUM_EN     = 1'b1;
    localparam logic [BYTE_W-1:0] RST_TERM_OFFSET = 8'd1;
    localparam logic [BYTE_W-1:0] RST_ZERO_OFFSET = 8'd1;
    localparam logic [BYTE_W-1:0] RST_MAX_LENGTH  = 8'd64;
    localparam logic [TICK_W-1:0] RST_TIMEOUT     = 16'd1000;

    // input kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // result kinds
    localparam logic OUT_PAYLOAD = 1'b0;
    localparam logic OUT_END     = 1'b1;

    // frame status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CSUM_ERR = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] start_mark;
        logic [BYTE_W-1:0] open_mark;
        logic [BYTE_W-1:0] end_mark;
        logic              checksum_enable;
        logic [BYTE_W-1:0] term_offset;
        logic [BYTE_W-1:0] zero_offset;
        logic [BYTE_W-1:0] max_length;
        logic [TICK_W-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic              out_kind;
        logic [BYTE_W-1:0] payload;
        logic [1:0]        status;
    } t_result;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_ARMED = 3'b010,
        PH_FRAME = 3'b100
    } t_phase;

endpackage

`default_nettype wire

>>> sv/cfr_cfg_regs.sv
// Configuration register file for the command frame receiver.
`default_nettype none

module cfr_cfg_regs (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [cfr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [cfr_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    output cfr_pkg::t_cfg                    o_cfg
);
    import cfr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_mark      <= RST_START_MARK;
            r_cfg.open_mark       <= RST_OPEN_MARK;
            r_cfg.end_mark        <= RST_END_MARK;
            r_cfg.checksum_enable <= RST_CSUM_EN;
            r_cfg.term_offset     <= RST_TERM_OFFSET;
            r_cfg.zero_offset     <= RST_ZERO_OFFSET;
            r_cfg.max_length      <= RST_MAX_LENGTH;
            r_cfg.timeout_ticks   <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_MARK:  r_cfg.start_mark      <= i_cfg_data[BYTE_W-1:0];
                REG_OPEN_MARK:   r_cfg.open_mark       <= i_cfg_data[BYTE_W-1:0];
                REG_END_MARK:    r_cfg.end_mark        <= i_cfg_data[BYTE_W-1:0];
                REG_CSUM_EN:     r_cfg.checksum_enable <= i_cfg_data[0];
                REG_TERM_OFFSET: r_cfg.term_offset     <= i_cfg_data[BYTE_W-1:0];
                REG_ZERO_OFFSET: r_cfg.zero_offset     <= i_cfg_data[BYTE_W-1:0];
                REG_MAX_LENGTH:  r_cfg.max_length      <= i_cfg_data[BYTE_W-1:0];
                REG_TIMEOUT:     r_cfg.timeout_ticks   <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> sv/cfr_core.sv
// Input register and frame state machine of the command frame receiver.
`default_nettype none

module cfr_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  cfr_pkg::t_cfg                  i_cfg,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire                            i_kind,
    input  wire  [cfr_pkg::BYTE_W-1:0]     i_rx_byte,
    input  wire                            i_res_full,
    output logic                           o_res_push,
    output cfr_pkg::t_result               o_res
);
    import cfr_pkg::*;

    logic                 r_in_valid;
    logic                 r_in_kind;
    logic [BYTE_W-1:0]    r_in_byte;

    t_phase               r_phase, n_phase;
    logic [BYTE_W-1:0]    r_count, n_count;
    logic [BYTE_W-1:0]    r_sum, n_sum;
    logic [BYTE_W-1:0]    r_held, n_held;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;

    logic                 advance;
    logic                 res_valid;
    t_result              res;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [BYTE_W-1:0]    csum;
    logic [BYTE_W-1:0]    count_inc;

    assign advance    = r_in_valid && !i_res_full;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_rx_byte;
        end
    end

    assign elapsed_inc = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign count_inc   = r_count + 1'b1;

    always_comb begin
        csum = r_sum;
        if (csum == i_cfg.end_mark) begin
            csum = csum + i_cfg.term_offset;
        end
        if (csum == '0) begin
            csum = csum + i_cfg.zero_offset;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_sum     = r_sum;
        n_held    = r_held;
        n_elapsed = r_elapsed;
        res_valid = 1'b0;
        res       = '{out_kind: OUT_PAYLOAD, payload: '0, status: ST_OK};

        if (r_in_kind == KIND_TICK) begin
            if (r_phase == PH_ARMED || r_phase == PH_FRAME) begin
                n_elapsed = elapsed_inc;
                if (elapsed_inc > {1'b0, i_cfg.timeout_ticks}) begin
                    n_phase      = PH_IDLE;
                    n_count      = '0;
                    n_sum        = '0;
                    n_held       = '0;
                    res_valid    = 1'b1;
                    res.out_kind = OUT_END;
                    res.status   = ST_TIMEOUT;
                end
            end
        end else begin
            case (r_phase)
                PH_ARMED: begin
                    n_phase = (r_in_byte == i_cfg.open_mark) ? PH_FRAME : PH_IDLE;
                    n_count = '0;
                    n_sum   = '0;
                    n_held  = '0;
                end
                PH_FRAME: begin
                    if (r_count >= i_cfg.max_length) begin
                        n_phase      = PH_IDLE;
                        n_count      = '0;
                        n_sum        = '0;
                        n_held       = '0;
                        res_valid    = 1'b1;
                        res.out_kind = OUT_END;
                        res.status   = ST_TOO_LONG;
                    end else if (r_in_byte == i_cfg.end_mark) begin
                        n_phase      = PH_IDLE;
                        n_count      = '0;
                        n_sum        = '0;
                        n_held       = '0;
                        res_valid    = 1'b1;
                        res.out_kind = OUT_END;
                        if (i_cfg.checksum_enable && r_count != '0 && csum != r_held) begin
                            res.status = ST_CSUM_ERR;
                        end
                    end else if (!i_cfg.checksum_enable) begin
                        n_count     = count_inc;
                        n_sum       = r_sum + r_in_byte;
                        n_held      = r_in_byte;
                        res_valid   = 1'b1;
                        res.payload = r_in_byte;
                    end else begin
                        if (r_count != '0) begin
                            n_sum       = r_sum + r_held;
                            res_valid   = 1'b1;
                            res.payload = r_held;
                        end
                        n_held  = r_in_byte;
                        n_count = count_inc;
                    end
                end
                default: begin
                    if (r_in_byte == i_cfg.start_mark) begin
                        n_phase   = PH_ARMED;
                        n_count   = '0;
                        n_sum     = '0;
                        n_held    = '0;
                        n_elapsed = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_sum     <= '0;
            r_held    <= '0;
            r_elapsed <= '0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_held    <= n_held;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_res_push = advance && res_valid;
    assign o_res      = res;

    // a payload item never carries a status, an end record never carries data
    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push && o_res.out_kind == OUT_PAYLOAD |-> o_res.status == ST_OK)
        else $error("payload item with nonzero status");

    a_end_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push && o_res.out_kind == OUT_END |-> o_res.payload == '0)
        else $error("end record with nonzero payload");

    // every end record leaves the receiver idle
    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push && o_res.out_kind == OUT_END |=> r_phase == PH_IDLE)
        else $error("receiver not idle after end record");

    // nothing is produced while idle
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_phase == PH_IDLE |-> !res_valid)
        else $error("result produced while idle");

    // state only moves when an item is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_phase) && $stable(r_count) && $stable(r_elapsed))
        else $error("state changed without an item");

endmodule

`default_nettype wire

>>> sv/cfr_out_fifo.sv
// Two-entry result buffer between the frame logic and the output channel.
`default_nettype none

module cfr_out_fifo (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_push,
    input  cfr_pkg::t_result              i_res,
    output logic                          o_full,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic                          o_out_kind,
    output logic [cfr_pkg::BYTE_W-1:0]    o_payload,
    output logic [1:0]                    o_status
);
    import cfr_pkg::*;

    t_result     r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;
    logic        pop;
    t_result     head;

    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_full      = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign head       = r_mem[r_rd_ptr];
    assign o_out_kind = head.out_kind;
    assign o_payload  = head.payload;
    assign o_status   = head.status;

endmodule

`default_nettype wire

>>> sv/command_frame_receiver_unit.sv
// Top level of the command frame receiver.
//
// Input channel: i_in_valid / o_in_ready carry one item: i_kind 0 is a received
// byte in i_rx_byte, i_kind 1 is one time tick. Output channel: o_out_valid /
// i_out_ready carry payload bytes (o_out_kind 0) and frame end records
// (o_out_kind 1, o_status 0 ok, 1 checksum error, 2 too long, 3 timeout).
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
// An accepted item is held in the input register, evaluated by the frame
// state logic and its result, if any, is written into a two-entry output
// buffer, from which it is offered on the output channel.
// One item per cycle is sustained while the output side keeps up. When the
// receiver stalls, up to two results plus one item in the input register are
// held; o_in_ready drops only when the output buffer is full and the input
// register is occupied. Synchronous reset empties both stages, returns the
// receiver to idle and loads the register defaults.
`default_nettype none

module command_frame_receiver_unit (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [cfr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [cfr_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire                             i_kind,
    input  wire  [cfr_pkg::BYTE_W-1:0]      i_rx_byte,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic                            o_out_kind,
    output logic [cfr_pkg::BYTE_W-1:0]      o_payload,
    output logic [1:0]                      o_status
);
    import cfr_pkg::*;

    t_cfg    cfg;
    t_result res;
    logic    res_push;
    logic    res_full;

    cfr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    cfr_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .i_rx_byte  (i_rx_byte),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res)
    );

    cfr_out_fifo u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_push),
        .i_res       (res),
        .o_full      (res_full),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_kind  (o_out_kind),
        .o_payload   (o_payload),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire
